// ===== rtl/stm_pkg.sv =====
// shared types, constants and the sine table helper for the stereo tone mixer
`default_nettype none

package stm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;  // phase bits carried to the back end
  localparam int STEP_BITS   = 31;
  localparam int AMP_BITS    = 16;
  localparam int CFG_ADDR_BITS = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [AMP_BITS:0] AMP_FULL = 17'd32768;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_AMPLITUDE    = 2'd1,
    REG_WAVEFORM     = 2'd2,
    REG_CHANNEL_MASK = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_SILENT = 2'd3
  } wave_t;

  // settings the back end needs
  typedef struct packed {
    logic [AMP_BITS-1:0] amplitude;
    wave_t               waveform;
    logic [1:0]          channel_mask;
  } stm_cfg_t;

  // one frame as it waits in the queue
  typedef struct packed {
    logic [FRAC_BITS-1:0]   phase_hi;
    logic [SAMPLE_BITS-1:0] right;
    logic [SAMPLE_BITS-1:0] left;
  } stm_item_t;

  // sin(x) in Q30 for 0 <= x < pi/2, taylor series to x^13, elaboration only
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    return (sum < 0) ? 64'd0 : unsigned'(sum);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/stm_queue.sv =====
// small frame queue between the front and back ends
`default_nettype none

module stm_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  stm_pkg::stm_item_t  push_item,
  output logic                full,
  input  wire                 pop,
  output logic                not_empty,
  output stm_pkg::stm_item_t  pop_item
);
  import stm_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  stm_item_t           mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == (PTR_BITS+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/stm_front.sv =====
// input side: takes frames, stamps each with its phase and advances the accumulator
`default_nettype none

module stm_front #(
  parameter int PHASE_BITS = 32
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire [2*stm_pkg::SAMPLE_BITS-1:0] s_tdata,   // left_in, right_in
  input  wire                              s_tlast,
  input  wire [stm_pkg::STEP_BITS-1:0]     phase_step,
  input  wire                              queue_full,
  output logic                             push,
  output stm_pkg::stm_item_t               push_item
);
  import stm_pkg::*;

  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_next;

  assign s_tready = !queue_full;
  assign push     = s_tvalid && s_tready;

  assign push_item.left     = s_tdata[SAMPLE_BITS-1:0];
  assign push_item.right    = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign push_item.phase_hi = phase[PHASE_BITS-1 -: FRAC_BITS];

  // a run restarts its phase after the frame marked last
  assign phase_next = s_tlast ? '0 : phase + PHASE_BITS'(phase_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (push) begin
      phase <= phase_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/stm_back.sv =====
// output side: waveform lookup, amplitude scaling and saturating mix
`default_nettype none

module stm_back #(
  parameter int SINE_TABLE_ADDR_BITS = 10
) (
  input  wire                              clk,
  input  wire                              rst,
  input  stm_pkg::stm_cfg_t                cfg,
  input  wire                              item_valid,
  input  stm_pkg::stm_item_t               item,
  output logic                             pop,
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [2*stm_pkg::SAMPLE_BITS-1:0] m_tdata   // left_out, right_out
);
  import stm_pkg::*;

  localparam int ABITS = SINE_TABLE_ADDR_BITS;
  localparam int KBITS = ABITS - 2;
  localparam int QSIZE = 1 << KBITS;

  typedef logic [SAMPLE_BITS-2:0] quarter_t [QSIZE];

  function automatic quarter_t build_quarter();
    quarter_t    t;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] v;
    for (int k = 0; k < QSIZE; k++) begin
      x = (HALF_PI_Q30 * (64'(2 * k) + 64'd1)) >> (KBITS + 1);
      s = sine_q30(x);
      v = (s * 64'(SAMPLE_MAX) + 64'd536870912) >> 30;
      if (v > 64'(SAMPLE_MAX)) begin
        v = 64'(SAMPLE_MAX);
      end
      t[k] = v[SAMPLE_BITS-2:0];
    end
    return t;
  endfunction

  localparam quarter_t QUARTER = build_quarter();

  logic                   adv;

  // stage 1: table read and saw product
  logic                   v1;
  logic [SAMPLE_BITS-2:0] tab1;
  logic                   neg1;
  logic [15:0]            saw1;
  logic [SAMPLE_BITS-1:0] left1;
  logic [SAMPLE_BITS-1:0] right1;

  // stage 2: scaled tone product
  logic                   v2;
  logic signed [34:0]     prod2;
  logic [SAMPLE_BITS-1:0] left2;
  logic [SAMPLE_BITS-1:0] right2;

  logic [ABITS-1:0]       idx;
  logic [KBITS-1:0]       addr;
  logic [31:0]            saw_prod;
  logic signed [16:0]     wave;
  logic [AMP_BITS:0]      amp_eff;
  logic signed [34:0]     rounded;
  logic signed [16:0]     tone;
  logic [SAMPLE_BITS-1:0] left_mix;
  logic [SAMPLE_BITS-1:0] right_mix;

  function automatic logic [SAMPLE_BITS-1:0] sat_add(
    input logic [SAMPLE_BITS-1:0] smp,
    input logic signed [16:0]     t
  );
    logic signed [17:0] s;
    s = 18'(signed'(smp)) + 18'(t);
    if (s > 18'(signed'(SAMPLE_MAX))) begin
      return SAMPLE_MAX;
    end else if (s < 18'(signed'(SAMPLE_MIN))) begin
      return SAMPLE_MIN;
    end
    return s[SAMPLE_BITS-1:0];
  endfunction

  // the whole back end moves together whenever the output register can take a beat
  assign adv = !m_tvalid || m_tready;
  assign pop = adv && item_valid;

  assign idx      = item.phase_hi[FRAC_BITS-1 -: ABITS];
  // odd quadrants read the quarter wave backward
  assign addr     = idx[KBITS] ? ~idx[KBITS-1:0] : idx[KBITS-1:0];
  assign saw_prod = 32'(item.phase_hi) * 32'(SAMPLE_MAX << 1);

  always_comb begin
    case (cfg.waveform)
      WAVE_SINE:   wave = neg1 ? -17'(tab1) : 17'(tab1);
      WAVE_SQUARE: wave = neg1 ? -17'(SAMPLE_MAX) : 17'(SAMPLE_MAX);
      WAVE_SAW:    wave = signed'({1'b0, saw1}) - 17'(SAMPLE_MAX);
      default:     wave = '0;
    endcase
  end

  assign amp_eff = (cfg.amplitude > AMP_FULL[AMP_BITS-1:0] && cfg.amplitude != 16'd0
                    && 17'(cfg.amplitude) > AMP_FULL) ? AMP_FULL : {1'b0, cfg.amplitude};

  // round half up, then the arithmetic shift floors
  assign rounded   = prod2 + 35'sd16384;
  assign tone      = rounded[31:15];
  assign left_mix  = cfg.channel_mask[0] ? sat_add(left2, tone) : left2;
  assign right_mix = cfg.channel_mask[1] ? sat_add(right2, tone) : right2;

  always_ff @(posedge clk) begin
    if (adv) begin
      tab1    <= QUARTER[addr];
      neg1    <= idx[ABITS-1];
      saw1    <= saw_prod[31:16];
      left1   <= item.left;
      right1  <= item.right;
      prod2   <= 35'(wave) * 35'(signed'({1'b0, amp_eff}));
      left2   <= left1;
      right2  <= right1;
      m_tdata <= {right_mix, left_mix};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      v1       <= item_valid;
      v2       <= v1;
      m_tvalid <= v2;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/stereo_tone_mixer_unit.sv =====
// top level of the stereo tone mixer: register file, front end, queue and back end
`default_nettype none

// Stereo tone mixer. Each beat on the slave stream is one stereo frame; the block adds a
// tone (sine from a quarter-wave table, square, saw, or silence, scaled by a Q1.15
// amplitude) to the selected channels with saturation and sends the frame out on the
// master stream. The phase used by a frame is the accumulator value before that frame's
// advance, and the accumulator returns to zero after a frame with tlast set. The block
// takes one frame per clock while the queue is not full. When nothing stalls, an accepted
// frame is written into the four-entry queue, then passes the table read, amplitude
// multiply and round/saturate stages before it leaves the output register. The queue lets
// the input keep running while the output is briefly held. Registers are written through
// the cfg port and should only change while no frames are in flight.
module stereo_tone_mixer_unit #(
  parameter int PHASE_BITS           = 32,
  parameter int SINE_TABLE_ADDR_BITS = 10
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  input  wire [2*stm_pkg::SAMPLE_BITS-1:0]     s_tdata,   // left_in, right_in
  input  wire                                  s_tlast,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  output logic [2*stm_pkg::SAMPLE_BITS-1:0]    m_tdata,   // left_out, right_out
  input  wire                                  cfg_we,
  input  wire [stm_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
  input  wire [stm_pkg::STEP_BITS-1:0]         cfg_wdata
);
  import stm_pkg::*;

  logic [STEP_BITS-1:0] phase_step;
  stm_cfg_t             cfg;
  logic                 queue_full;
  logic                 push;
  stm_item_t            push_item;
  logic                 pop;
  logic                 item_valid;
  stm_item_t            item;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step       <= '0;
      cfg.amplitude    <= '0;
      cfg.waveform     <= WAVE_SINE;
      cfg.channel_mask <= 2'b11;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_PHASE_STEP:   phase_step       <= cfg_wdata;
        REG_AMPLITUDE:    cfg.amplitude    <= cfg_wdata[AMP_BITS-1:0];
        REG_WAVEFORM:     cfg.waveform     <= wave_t'(cfg_wdata[1:0]);
        REG_CHANNEL_MASK: cfg.channel_mask <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  stm_front #(
    .PHASE_BITS (PHASE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .phase_step (phase_step),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  stm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (item_valid),
    .pop_item  (item)
  );

  stm_back #(
    .SINE_TABLE_ADDR_BITS (SINE_TABLE_ADDR_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

// ===== dv/stereo_tone_mixer_unit_test.sv =====
// stream-level test of the stereo tone mixer against a behavioral tone and mix predictor
`timescale 1ns / 1ps

module stereo_tone_mixer_unit_test;
  import stm_pkg::*;

  localparam int FULL_LEVEL      = 32767;
  localparam int QUARTER_ENTRIES = 256;
  localparam int RANDOM_PHASES   = 16;
  localparam int FRAMES_PER_SET  = 100;
  localparam int PAUSE_PHASE     = 5;
  localparam int CALM_PHASE      = 2;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [15:0] right;
    logic [15:0] left;
  } stereo_frame_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  wire         s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [31:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [30:0] cfg_wdata = '0;

  logic        calm = 1'b0;
  int unsigned frames_sent = 0;
  int unsigned settings_count = 0;
  int unsigned quiet_cycles = 0;

  stereo_tone_mixer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // left_in, right_in
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // left_out, right_out
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  class mix_predictor;
    logic [30:0]   phase_step;
    logic [15:0]   amplitude;
    wave_t         waveform;
    logic [1:0]    channel_mask;
    logic [31:0]   phase;
    int            quarter_sine[QUARTER_ENTRIES];
    stereo_frame_t pending_frames[$];
    int unsigned   results_seen;
    int unsigned   errors;

    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint          v;
      int              k;
      int              n;
      for (k = 0; k < QUARTER_ENTRIES; k++) begin
        x = (HALF_PI_Q30 * (2 * k + 1)) / (2 * QUARTER_ENTRIES);
        x2 = (x * x) >> 30;
        term = x;
        sum = x;
        // taylor series up to x^13, each term truncated
        for (n = 1; n <= 6; n++) begin
          term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
          if (n % 2 == 1) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        v = (sum * FULL_LEVEL + (64'd1 << 29)) >>> 30;
        if (v > FULL_LEVEL) v = FULL_LEVEL;
        quarter_sine[k] = int'(v);
      end
      phase_step = '0;
      amplitude = '0;
      waveform = WAVE_SINE;
      channel_mask = 2'b11;
      phase = '0;
      results_seen = 0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [30:0] value);
      case (idx)
        REG_PHASE_STEP:   phase_step = value;
        REG_AMPLITUDE:    amplitude = value[15:0];
        REG_WAVEFORM:     waveform = wave_t'(value[1:0]);
        REG_CHANNEL_MASK: channel_mask = value[1:0];
        default: ;
      endcase
    endfunction

    function longint tone_now();
      logic [9:0] idx;
      longint     w;
      longint     amp;
      longint     f;
      int         k;
      idx = phase[31:22];
      k = idx[7:0];
      f = phase[31:16];
      case (waveform)
        WAVE_SINE: begin
          case (idx[9:8])
            2'd0: w = quarter_sine[k];
            2'd1: w = quarter_sine[QUARTER_ENTRIES - 1 - k];
            2'd2: w = -quarter_sine[k];
            default: w = -quarter_sine[QUARTER_ENTRIES - 1 - k];
          endcase
        end
        WAVE_SQUARE: w = idx[9] ? -FULL_LEVEL : FULL_LEVEL;
        WAVE_SAW:    w = ((f * (2 * FULL_LEVEL)) >>> 16) - FULL_LEVEL;
        default:     w = 0;
      endcase
      amp = (amplitude > AMP_FULL) ? longint'(AMP_FULL) : longint'(amplitude);
      // floor division, rounds half upward
      return (w * amp + 16384) >>> 15;
    endfunction

    function logic [15:0] saturating_add(logic [15:0] sample, longint tone);
      longint s;
      s = $signed(sample);
      s = s + tone;
      if (s > FULL_LEVEL) s = FULL_LEVEL;
      if (s < -FULL_LEVEL - 1) s = -FULL_LEVEL - 1;
      return s[15:0];
    endfunction

    function void note_frame(logic [31:0] data, logic last_frame);
      stereo_frame_t want;
      longint        tone;
      tone = tone_now();
      want.left  = channel_mask[0] ? saturating_add(data[15:0], tone) : data[15:0];
      want.right = channel_mask[1] ? saturating_add(data[31:16], tone) : data[31:16];
      pending_frames.push_back(want);
      phase = phase + {1'b0, phase_step};
      if (last_frame) phase = '0;
    endfunction

    function void flag(string what, logic [15:0] want, logic [15:0] got);
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("mismatch on %s: expected %0d, got %0d", what, $signed(want), $signed(got));
    endfunction

    function void check_frame(logic [31:0] data);
      stereo_frame_t want;
      results_seen++;
      if (pending_frames.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("result beat with no frame waiting: %h", data);
      end else begin
        want = pending_frames.pop_front();
        if (data[15:0] !== want.left) flag("left_out", want.left, data[15:0]);
        if (data[31:16] !== want.right) flag("right_out", want.right, data[31:16]);
      end
    endfunction
  endclass

  mix_predictor sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // input beats are noted before results are checked in the same cycle
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_frame(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_frame(m_tdata);
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= calm || ($urandom_range(99) >= 19);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(input logic [15:0] left, input logic [15:0] right,
                            input logic last_frame);
    while (!calm && $urandom_range(99) < 19) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {right, left};
    s_tlast  <= last_frame;
    do @(posedge clk); while (!s_tready);
    frames_sent++;
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.results_seen < frames_sent);
  endtask

  task automatic program_regs(input logic [30:0] step_w, input logic [30:0] amp_w,
                              input logic [30:0] wave_w, input logic [30:0] mask_w);
    logic [30:0] words[4];
    words = '{step_w, amp_w, wave_w, mask_w};
    for (int r = 0; r < 4; r++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= reg_idx_t'(r);
      cfg_wdata <= words[r];
      @(posedge clk);
      sb.write_reg(reg_idx_t'(r), words[r]);
    end
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  initial begin
    logic [30:0] step_w;
    logic [30:0] amp_w;
    logic [30:0] wave_w;
    logic [30:0] mask_w;
    logic [28:0] junk;
    logic [15:0] amp;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero amplitude, samples pass through
    send_frame(16'h7FFF, 16'h8000, 1'b0);
    send_frame(16'h0000, 16'hFFFF, 1'b1);
    hold_until_drained();

    // quarter-turn steps walk the sine through all four quadrants, then restart
    program_regs(31'h4000_0000, 31'(AMP_FULL), 31'(WAVE_SINE), 31'd3);
    send_frame(16'h7FFF, 16'h7FFF, 1'b0);
    send_frame(16'h8000, 16'h8000, 1'b0);
    send_frame(16'h8000, 16'h8000, 1'b0);
    send_frame(16'h0000, 16'h0000, 1'b0);
    send_frame(16'd100, -16'sd100, 1'b1);
    send_frame(16'h0001, 16'h0001, 1'b0);
    hold_until_drained();

    // square at clamped amplitude, largest step wraps the phase, left only
    program_regs(31'h7FFF_FFFF, 31'h0000_FFFF, 31'(WAVE_SQUARE), 31'd1);
    send_frame(16'h7FFF, 16'h8000, 1'b0);
    send_frame(16'h8000, 16'h7FFF, 1'b0);
    send_frame(16'hFFFF, 16'h0000, 1'b0);
    send_frame(16'h0000, 16'h0000, 1'b1);
    hold_until_drained();

    // saw at the smallest amplitude, right only
    program_regs(31'h0123_4567, 31'd1, 31'(WAVE_SAW), 31'd2);
    send_frame(16'd5, 16'd5, 1'b0);
    send_frame(16'h0000, 16'h8000, 1'b0);
    send_frame(16'h7FFF, 16'h7FFF, 1'b0);
    hold_until_drained();

    // silent code with junk in the upper register bits
    program_regs(31'h1000_0000, 31'h7FFF_8000, 31'h5555_5557, 31'h7FFF_FFFF);
    send_frame(16'd1234, -16'sd1234, 1'b0);
    send_frame(16'h7FFF, 16'h8000, 1'b1);
    hold_until_drained();

    // full sine but no channel selected
    program_regs(31'h0800_0000, 31'(AMP_FULL), 31'(WAVE_SINE), 31'd0);
    send_frame(16'h7FFF, 16'h8000, 1'b0);
    send_frame(16'h0000, 16'h0000, 1'b0);
    hold_until_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: program_regs(31'h7FFF_FFFF, 31'(AMP_FULL), 31'(WAVE_SINE), 31'd3);
        1: program_regs(31'd0, 31'h0000_FFFF, 31'(WAVE_SQUARE), 31'd3);
        default: begin
          case ($urandom_range(3))
            0: step_w = 31'($urandom_range(0, 65535));
            1: step_w = 31'h7FFF_FFFF - 31'($urandom_range(0, 255));
            default: step_w = 31'($urandom);
          endcase
          case ($urandom_range(5))
            0: amp = 16'd0;
            1: amp = AMP_FULL[15:0];
            2: amp = 16'd32767;
            3: amp = 16'($urandom_range(32769, 65535));
            default: amp = 16'($urandom_range(0, 32768));
          endcase
          junk = 29'($urandom);
          amp_w = {junk[14:0], amp};
          junk = 29'($urandom);
          wave_w = {junk, 2'($urandom_range(3))};
          junk = 29'($urandom);
          mask_w = {junk, 2'($urandom_range(3))};
          program_regs(step_w, amp_w, wave_w, mask_w);
        end
      endcase
      calm = (p == CALM_PHASE);
      for (int i = 0; i < FRAMES_PER_SET; i++) begin
        // let the output side empty completely mid-run
        if (p == PAUSE_PHASE && i == FRAMES_PER_SET / 2) hold_until_drained();
        send_frame(pick_sample(), pick_sample(), $urandom_range(15) == 0);
      end
      calm = 1'b0;
      hold_until_drained();
    end

    repeat (8) @(posedge clk);
    $display("sent %0d frames under %0d register settings, all waveforms and masks",
             frames_sent, settings_count);
    $display("checked %0d result beats, %0d mismatches, %0d still expected",
             sb.results_seen, sb.errors, sb.pending_frames.size());
    if (sb.errors == 0 && sb.pending_frames.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
